// ===== src/tfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tfs_pkg: shared types and constants
// Widths, sequencer states and divider request and response types for the fuzzifier.
// ----------------------------------------------------------------------------
package tfs_pkg;

    localparam int MAX_CATEGORIES_DEF = 16;
    localparam logic [14:0] WEIGHT_FULL = 15'd25600;
    localparam int DIV_W = 32;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [1:0] ADDR_NUM_CATEGORIES = 2'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WREAD,
        S_WDIV,
        S_WWAIT,
        S_DRAW,
        S_DWAIT,
        S_WALK,
        S_MREAD,
        S_MWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [DIV_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [DIV_W-1:0]  rem;
    } t_div_rsp;

endpackage

// ===== src/triangular_fuzzifier_select.sv =====
// Sequencing: a load writes its slot's triangle on acceptance; a classify of N categories
//   runs its divisions on the shared divider (at most one per weight, one for the
//   draw, one per membership), so its results wait on the divider.
// Throughput: one transaction at a time; each result waits for m_axis_tready.
// Reset: synchronous active-low; clears control and num_categories; the
//   triangle memory and weights are undefined until written.
// ----------------------------------------------------------------------------
// triangular_fuzzifier_select: triangular membership fuzzifier
// Computes weighted memberships and a roulette pick over loaded triangles.
// ----------------------------------------------------------------------------
module triangular_fuzzifier_select #(
    parameter int MAX_CATEGORIES = tfs_pkg::MAX_CATEGORIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[3:0], point_low[19:4], point_mid[35:20], point_high[51:36],
    // sample[67:52], random_word[83:68]
    input  logic [87:0] s_axis_tdata,
    // op
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // category_slot[3:0], membership[19:4], chosen[23:20]
    output logic [23:0] m_axis_tdata,
    // out_of_range
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tfs_pkg::*;

    localparam int IW = (MAX_CATEGORIES > 1) ? $clog2(MAX_CATEGORIES) : 1;
    localparam int CW = $clog2(MAX_CATEGORIES + 1);
    localparam int TW = 15 + CW;
    localparam int NLIM = (MAX_CATEGORIES < 16) ? MAX_CATEGORIES : 16;

    logic              in_op;
    logic [3:0]        in_slot;
    logic signed [15:0] in_lo, in_mi, in_hi, in_x;
    logic [15:0]       in_rand;

    assign in_op   = s_axis_tuser;
    assign in_slot = s_axis_tdata[3:0];
    assign in_lo   = s_axis_tdata[19:4];
    assign in_mi   = s_axis_tdata[35:20];
    assign in_hi   = s_axis_tdata[51:36];
    assign in_x    = s_axis_tdata[67:52];
    assign in_rand = s_axis_tdata[83:68];

    logic [47:0] mem_tri [MAX_CATEGORIES];
    logic [14:0] mem_w   [MAX_CATEGORIES];
    logic [47:0] r_tri_q;
    logic [14:0] r_w_q;

    logic [4:0]  r_ncfg;
    t_state      r_state, n_state;
    logic [CW-1:0] r_ncat, n_ncat;
    logic [CW-1:0] r_k, n_k;
    logic signed [15:0] r_x, n_x;
    logic [15:0] r_rand, n_rand;
    logic [TW-1:0] r_total, n_total;
    logic [TW-1:0] r_run, n_run;
    logic [15:0] r_draw, n_draw;
    logic [IW-1:0] r_chosen, n_chosen;
    logic        r_wzero, n_wzero;
    logic        r_walk_done, n_walk_done;
    logic [15:0] r_mem, n_mem;

    logic        accept, out_fire;
    logic        w_we;
    logic [14:0] w_wd;
    logic [IW-1:0] rd_idx;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    tfs_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    logic signed [16:0] t_lo, t_mi, t_hi, t_x;
    logic [16:0] num_d, den_d;
    logic        branch_ok, at_mid;
    logic [4:0]  cfg_clamped;
    logic [TW-9:0] intpart;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ADDR_NUM_CATEGORIES[0]) ? {27'd0, r_ncfg} : 32'd0;
    assign rd_idx   = r_k[IW-1:0];

    assign t_lo = 17'($signed(r_tri_q[15:0]));
    assign t_mi = 17'($signed(r_tri_q[31:16]));
    assign t_hi = 17'($signed(r_tri_q[47:32]));
    assign t_x  = 17'(r_x);
    assign at_mid = (t_x == t_mi);
    always_comb begin
        branch_ok = 1'b0;
        num_d = '0;
        den_d = '1;
        if (t_x > t_lo && t_x < t_hi && !at_mid) begin
            branch_ok = 1'b1;
            if (t_x > t_mi) begin
                num_d = 17'(t_hi - t_x);
                den_d = 17'(t_hi - t_mi);
            end else begin
                num_d = 17'(t_x - t_lo);
                den_d = 17'(t_mi - t_lo);
            end
        end
    end

    assign cfg_clamped = (32'(r_ncfg) > NLIM) ? 5'(NLIM) : r_ncfg;
    assign intpart = r_total[TW-1:8];

    always_ff @(posedge i_clk) begin
        if (accept && in_op == OP_LOAD && 32'(in_slot) < MAX_CATEGORIES)
            mem_tri[IW'(in_slot)] <= {in_hi, in_mi, in_lo};
        if (w_we)
            mem_w[rd_idx] <= w_wd;
        r_tri_q <= mem_tri[rd_idx];
        r_w_q   <= mem_w[rd_idx];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && in_op == OP_CLASSIFY && cfg_clamped != 5'd0)
                         n_state = S_WREAD;
            S_WREAD: n_state = S_WDIV;
            S_WDIV:  n_state = branch_ok ? S_WWAIT :
                               (r_k == r_ncat - 1'b1 ? S_DRAW : S_WREAD);
            S_WWAIT: if (div_rsp.done)
                         n_state = (r_k == r_ncat - 1'b1) ? S_DRAW : S_WREAD;
            S_DRAW:  n_state = (r_total == '0 || intpart == '0) ? S_WALK : S_DWAIT;
            S_DWAIT: if (div_rsp.done) n_state = S_WALK;
            S_WALK:  if (r_walk_done) n_state = S_MREAD;
            S_MREAD: n_state = S_MWAIT;
            S_MWAIT: if (r_total == '0 || div_rsp.done) n_state = S_OUT;
            S_OUT:   if (out_fire)
                         n_state = (r_k == r_ncat - 1'b1) ? S_IDLE : S_MREAD;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ncat = r_ncat; n_k = r_k; n_x = r_x; n_rand = r_rand;
        n_total = r_total; n_run = r_run; n_draw = r_draw;
        n_chosen = r_chosen; n_wzero = r_wzero; n_walk_done = r_walk_done;
        n_mem = r_mem;
        w_we = 1'b0; w_wd = '0;
        div_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_op == OP_CLASSIFY) begin
                    n_ncat = CW'(cfg_clamped);
                    n_k = '0; n_x = in_x; n_rand = in_rand; n_total = '0;
                end
            end
            S_WREAD: ;
            S_WDIV: begin
                if (branch_ok) begin
                    div_req.start = 1'b1;
                    div_req.num = DIV_W'(num_d) * DIV_W'(WEIGHT_FULL);
                    div_req.den = DIV_W'(den_d);
                end else begin
                    w_we = 1'b1;
                    w_wd = at_mid && t_x > t_lo && t_x < t_hi ? WEIGHT_FULL : 15'd0;
                    n_total = r_total + TW'(w_wd);
                    n_k = r_k + 1'b1;
                end
            end
            S_WWAIT: begin
                if (div_rsp.done) begin
                    w_we = 1'b1;
                    w_wd = div_rsp.quo[14:0];
                    n_total = r_total + TW'(w_wd);
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAW: begin
                n_k = '0; n_chosen = '0; n_walk_done = 1'b0; n_wzero = 1'b1;
                n_draw = '0;
                if (r_total != '0 && intpart != '0) begin
                    div_req.start = 1'b1;
                    div_req.num = DIV_W'(r_rand);
                    div_req.den = DIV_W'(intpart);
                end
                if (r_total == '0) n_walk_done = 1'b1;
            end
            S_DWAIT: if (div_rsp.done) n_draw = div_rsp.rem[15:0];
            S_WALK: begin
                if (!r_walk_done) begin
                    if (r_wzero) begin
                        n_run = TW'(r_w_q);
                        n_wzero = 1'b0;
                        if (!(TW'(r_w_q) < TW'({r_draw, 8'd0})) || r_k == r_ncat - 1'b1)
                            n_walk_done = 1'b1;
                        else n_k = r_k + 1'b1;
                    end else if (r_k == CW'(r_chosen) + 1'b1) begin
                        // weight read for the new index lands next cycle
                        n_chosen = r_k[IW-1:0];
                    end else begin
                        n_run = r_run + TW'(r_w_q);
                        if (!(r_run + TW'(r_w_q) < TW'({r_draw, 8'd0})) ||
                            r_k == r_ncat - 1'b1)
                            n_walk_done = 1'b1;
                        else n_k = r_k + 1'b1;
                    end
                end else n_k = '0;
            end
            S_MREAD: ;
            S_MWAIT: begin
                if (r_total == '0) n_mem = '0;
                else if (!div_rsp.busy && !div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num = DIV_W'({r_w_q, 15'd0});
                    div_req.den = DIV_W'(r_total);
                end
                if (div_rsp.done) n_mem = div_rsp.quo[15:0];
            end
            S_OUT: if (out_fire) n_k = r_k + 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ncfg  <= '0;
            r_k     <= '0;
            r_walk_done <= 1'b0;
            r_wzero <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_walk_done <= n_walk_done;
            r_wzero <= n_wzero;
            if (psel && penable && pwrite && pready && paddr[2] == ADDR_NUM_CATEGORIES[0])
                r_ncfg <= pwdata[4:0];
        end
        r_ncat <= n_ncat; r_x <= n_x; r_rand <= n_rand; r_total <= n_total;
        r_run <= n_run; r_draw <= n_draw; r_chosen <= n_chosen; r_mem <= n_mem;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {4'(r_chosen), r_mem, 4'(r_k)};
    assign m_axis_tuser  = (r_total == '0);
    assign m_axis_tlast  = (r_k == r_ncat - 1'b1);

endmodule

// ===== src/tfs_divider.sv =====
// ----------------------------------------------------------------------------
// tfs_divider: shared restoring divider
// Unsigned 32/32 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfs_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfs_pkg::t_div_req i_req,
    output tfs_pkg::t_div_rsp o_rsp
);
    import tfs_pkg::*;

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quo, n_quo;
    logic [DIV_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0] r_den, n_den;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DIV_W:0]   trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = '0;
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_den  = i_req.den;
            n_cnt  = CW'(DIV_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            trial = {r_rem, r_quo[DIV_W-1]} - {1'b0, r_den};
            if (!trial[DIV_W]) begin
                n_rem = trial[DIV_W-1:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = {r_rem[DIV_W-2:0], r_quo[DIV_W-1]};
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule
